// ----- hw/rtl/ple_pkg.sv -----
// ============================================================================
// ple_pkg - positional list engine shared types
// Command and status codes, word structs and cell control for the list row.
// ============================================================================
package ple_pkg;

    localparam int PLE_DEPTH     = 16;
    localparam int PLE_DATA_W    = 32;
    localparam int PLE_POS_W     = 5;
    localparam int PLE_COUNT_W   = 5;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INS  = 2'd1,
        OP_REM  = 2'd2
    } t_op;

    typedef struct packed {
        t_cmd                         cmd;
        logic [PLE_POS_W-1:0]         position;
        logic                         from_front;
        logic signed [PLE_DATA_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        t_status                      status;
        logic signed [PLE_DATA_W-1:0] word_out;
        logic [PLE_COUNT_W-1:0]       count;
        logic                         empty_res;
    } t_out_word;

    // shift control broadcast along the row of cells
    typedef struct packed {
        t_op                          op;
        logic signed [PLE_DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

// ----- hw/rtl/positional_list_engine_unit.sv -----
// ============================================================================
// positional_list_engine_unit - bounded ordered list of signed words
// Insert, remove or read at a position counted from either end, or clear the list; the
// words sit in a row of cells, and insert or remove shifts the cells from the target slot on.
// ============================================================================
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+-----------
//  in      | input     | i_in_valid / o_in_ready | t_in_word
//  out     | output    | o_out_valid/i_out_ready | t_out_word
//
//  One command per cycle sustained while the consumer does not stall the output.
//  The accept edge checks the position against the fill count and registers
//  the decision; the retire edge shifts the affected cells and loads the result.
//  A result held by a stalled consumer holds the pending command, and the
//  input stalls behind it. Reset empties the list; cell contents stay stale.
// ============================================================================
module positional_list_engine_unit #(
    parameter int DEPTH = ple_pkg::PLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ple_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ple_pkg::t_out_word o_out_word
);
    import ple_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = ((FW > PLE_POS_W) ? FW : PLE_POS_W) + 1;

    logic [FW-1:0]                r_fill;
    logic [FW-1:0]                n_fill;
    logic                         r_busy;
    t_op                          r_op;
    t_op                          n_op;
    logic                         r_rd;
    logic                         n_rd;
    t_status                      r_status;
    t_status                      n_status;
    logic [IW-1:0]                r_idx;
    logic [IW-1:0]                n_idx;
    logic signed [PLE_DATA_W-1:0] r_val;
    logic                         r_out_valid;
    t_out_word                    r_out;

    logic                         w_accept;
    logic                         w_retire;
    logic [CW-1:0]                w_pos;
    logic [CW-1:0]                w_fill;
    logic                         w_ins_ok;
    logic                         w_rd_ok;
    logic                         w_full;
    logic [CW-1:0]                w_idx_ins;
    logic [CW-1:0]                w_idx_rd;
    t_cell_ctl                    w_ctl;
    logic signed [PLE_DATA_W-1:0] w_word [DEPTH];
    logic signed [PLE_DATA_W-1:0] w_tap  [DEPTH];
    logic signed [PLE_DATA_W-1:0] w_tap_or;

    assign w_retire   = r_busy && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_busy || w_retire;
    assign w_accept   = i_in_valid && o_in_ready;

    // position checks against the current fill count
    assign w_pos     = CW'(i_in_word.position);
    assign w_fill    = CW'(r_fill);
    assign w_ins_ok  = (w_pos != '0) && (w_pos <= w_fill + CW'(1));
    assign w_rd_ok   = (w_pos != '0) && (w_pos <= w_fill);
    assign w_full    = (r_fill == FW'(DEPTH));
    assign w_idx_ins = i_in_word.from_front ? (w_pos - CW'(1))
                                            : (w_fill + CW'(1) - w_pos);
    assign w_idx_rd  = i_in_word.from_front ? (w_pos - CW'(1)) : (w_fill - w_pos);

    always_comb begin
        n_op     = OP_NONE;
        n_rd     = 1'b0;
        n_status = ST_OK;
        n_idx    = '0;
        n_fill   = r_fill;
        unique case (i_in_word.cmd)
            CMD_INSERT: begin
                if (!w_ins_ok) begin
                    n_status = ST_RANGE;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_op   = OP_INS;
                    n_idx  = w_idx_ins[IW-1:0];
                    n_fill = r_fill + FW'(1);
                end
            end
            CMD_REMOVE: begin
                if (!w_rd_ok) begin
                    n_status = ST_RANGE;
                end else begin
                    n_op   = OP_REM;
                    n_rd   = 1'b1;
                    n_idx  = w_idx_rd[IW-1:0];
                    n_fill = r_fill - FW'(1);
                end
            end
            CMD_READ: begin
                if (!w_rd_ok) begin
                    n_status = ST_RANGE;
                end else begin
                    n_rd  = 1'b1;
                    n_idx = w_idx_rd[IW-1:0];
                end
            end
            CMD_CLEAR: begin
                n_fill = '0;
            end
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_fill      <= '0;
            r_op        <= OP_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                r_fill <= n_fill;
                r_op   <= n_op;
            end else if (w_retire) begin
                r_busy <= 1'b0;
            end
            if (w_retire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd     <= n_rd;
            r_status <= n_status;
            r_idx    <= n_idx;
            r_val    <= i_in_word.value;
        end
        if (w_retire) begin
            r_out.status    <= r_status;
            r_out.word_out  <= r_rd ? w_tap_or : '0;
            r_out.count     <= PLE_COUNT_W'(r_fill);
            r_out.empty_res <= (r_fill == '0);
        end
    end

    // fill count was updated at accept, so r_fill is the post-command count here
    assign w_ctl.op    = w_retire ? r_op : OP_NONE;
    assign w_ctl.value = r_val;

    for (genvar s = 0; s < DEPTH; s++) begin : g_cell
        logic signed [PLE_DATA_W-1:0] w_left;
        logic signed [PLE_DATA_W-1:0] w_right;
        if (s == 0) begin : g_first
            assign w_left = r_val;
        end else begin : g_mid_l
            assign w_left = w_word[s-1];
        end
        if (s == DEPTH - 1) begin : g_last
            assign w_right = w_word[s];
        end else begin : g_mid_r
            assign w_right = w_word[s+1];
        end
        ple_cell #(
            .IW   (IW),
            .SLOT (s)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_idx   (r_idx),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_word[s]),
            .o_tap   (w_tap[s])
        );
    end

    always_comb begin
        w_tap_or = '0;
        for (int s = 0; s < DEPTH; s++) begin
            w_tap_or = w_tap_or | w_tap[s];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill count beyond depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_word.cmd == CMD_CLEAR) |=> (r_fill == '0))
        else $error("clear left words in the list");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.empty_res == (o_out_word.count == '0)))
        else $error("empty flag disagrees with count");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status != ST_OK) |-> (o_out_word.word_out == '0))
        else $error("rejected command returned a word");

    a_shift_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op != OP_NONE) |-> r_busy)
        else $error("cell row shifted with no command pending");

endmodule

// ----- hw/rtl/ple_cell.sv -----
// ============================================================================
// ple_cell - one slot of the list row
// Holds one word; takes the left neighbour's word on insert shifts, the right
// neighbour's on remove shifts, and offers its word on the read tap.
// ============================================================================
module ple_cell #(
    parameter int IW   = 4,
    parameter int SLOT = 0
) (
    input  logic                                   i_clk,
    input  ple_pkg::t_cell_ctl                     i_ctl,
    input  logic [IW-1:0]                          i_idx,
    input  logic signed [ple_pkg::PLE_DATA_W-1:0]  i_left,
    input  logic signed [ple_pkg::PLE_DATA_W-1:0]  i_right,
    output logic signed [ple_pkg::PLE_DATA_W-1:0]  o_word,
    output logic signed [ple_pkg::PLE_DATA_W-1:0]  o_tap
);
    import ple_pkg::*;

    localparam logic [IW-1:0] MY_SLOT = IW'(SLOT);

    logic signed [PLE_DATA_W-1:0] r_word;
    logic signed [PLE_DATA_W-1:0] n_word;
    logic                         w_hit;
    logic                         w_after;

    assign w_hit   = (i_idx == MY_SLOT);
    assign w_after = (MY_SLOT > i_idx);

    always_comb begin
        n_word = r_word;
        unique case (i_ctl.op)
            OP_INS: begin
                if (w_after) begin
                    n_word = i_left;
                end else if (w_hit) begin
                    n_word = i_ctl.value;
                end
            end
            OP_REM: begin
                if (w_after || w_hit) begin
                    n_word = i_right;
                end
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_tap  = w_hit ? r_word : '0;

endmodule
